// ===== hdl/ffsa_pkg.sv =====
// Shared types and constants of the first-fit segment allocator.
package ffsa_pkg;

	localparam int MAX_SEGMENTS = 16;
	localparam int ADDR_BITS    = 16;
	localparam int IDX_W        = $clog2(MAX_SEGMENTS);
	localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
	localparam logic [15:0] TOTAL_SIZE_RESET = 16'd1024;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_NOFIT = 3'd1,
		ST_FULL  = 3'd2,
		ST_NOID  = 3'd3,
		ST_ZERO  = 3'd4
	} status_t;

	typedef struct packed {
		logic                 busy;
		logic [7:0]           owner;
		logic [ADDR_BITS-1:0] length;
		logic [ADDR_BITS-1:0] start;
	} seg_t;

	typedef struct packed {
		logic       valid;
		status_t    status;
		logic [15:0] addr;
	} result_t;

endpackage

// ===== hdl/ffsa_ifs.sv =====
// Handshake interfaces for the request, response and configuration channels.
interface ffsa_req_if;
	logic        valid;
	logic        ready;
	logic [0:0]  op;
	logic [7:0]  owner_id;
	logic [15:0] req_size;
	modport source (output valid, op, owner_id, req_size, input ready);
	modport sink (input valid, op, owner_id, req_size, output ready);
endinterface

interface ffsa_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] start_addr;
	modport source (output valid, status, start_addr, input ready);
	modport sink (input valid, status, start_addr, output ready);
endinterface

interface ffsa_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] total_size;
	modport source (output valid, total_size, input ready);
	modport sink (input valid, total_size, output ready);
endinterface

// ===== hdl/ffsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ffsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hdl/ffsa_seq.sv =====
// Table sequencer: scans, splits, shifts and compacts the segment table in RAM.
module ffsa_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  init,
	input  logic [15:0]           total_size,
	input  logic                  start,
	input  logic [0:0]            op,
	input  logic [7:0]            owner_id,
	input  logic [15:0]           req_size,
	output logic                  idle,
	output ffsa_pkg::result_t     res,
	input  logic                  res_take
);
	import ffsa_pkg::*;

	typedef enum logic [11:0] {
		S_INIT  = 12'b0000_0000_0001,
		S_IDLE  = 12'b0000_0000_0010,
		S_A_RD  = 12'b0000_0000_0100,
		S_A_CHK = 12'b0000_0000_1000,
		S_SH_RD = 12'b0000_0001_0000,
		S_SH_WR = 12'b0000_0010_0000,
		S_SP_HI = 12'b0000_0100_0000,
		S_SP_LO = 12'b0000_1000_0000,
		S_F_RD  = 12'b0001_0000_0000,
		S_F_CHK = 12'b0010_0000_0000,
		S_F_FL  = 12'b0100_0000_0000,
		S_DONE  = 12'b1000_0000_0000
	} state_t;

	state_t               state_q;
	logic [IDX_W-1:0]     i_q;
	logic [IDX_W-1:0]     w_q;
	logic [CNT_W-1:0]     k_q;
	logic [CNT_W-1:0]     cnt_q;
	seg_t                 ent_q;
	seg_t                 acc_q;
	logic                 acc_v_q;
	logic                 found_q;
	logic [7:0]           id_q;
	logic [ADDR_BITS-1:0] req_q;
	status_t              status_q;
	logic [15:0]          addr_q;

	logic                 we;
	logic [IDX_W-1:0]     waddr;
	seg_t                 wdata;
	logic                 re;
	logic [IDX_W-1:0]     raddr;
	seg_t                 rd_e;
	seg_t                 d_free;
	logic                 hit;
	logic                 merge;
	logic                 fit;
	logic                 exact;
	logic                 last;

	ffsa_ram #(
		.WIDTH($bits(seg_t)),
		.DEPTH(MAX_SEGMENTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rd_e)
	);

	always_comb begin
		hit    = rd_e.busy && (rd_e.owner == id_q);
		d_free = rd_e;
		if (hit) begin
			d_free.busy  = 1'b0;
			d_free.owner = 8'd0;
		end
		merge = acc_v_q && !acc_q.busy && !d_free.busy;
		fit   = !rd_e.busy && (rd_e.length >= req_q);
		exact = rd_e.length == req_q;
		last  = ({1'b0, i_q} == (cnt_q - CNT_W'(1)));
	end

	always_comb begin
		re    = 1'b0;
		raddr = i_q;
		we    = 1'b0;
		waddr = i_q;
		wdata = ent_q;
		unique case (state_q)
			S_INIT: begin
				we    = 1'b1;
				waddr = '0;
				wdata = '{busy: 1'b0, owner: 8'd0,
					length: ADDR_BITS'(total_size), start: '0};
			end
			S_A_RD, S_F_RD: begin
				re = 1'b1;
			end
			S_A_CHK: begin
				if (fit && exact) begin
					we    = 1'b1;
					wdata = '{busy: 1'b1, owner: id_q, length: rd_e.length,
						start: rd_e.start};
				end
			end
			S_SH_RD: begin
				re    = 1'b1;
				raddr = IDX_W'(k_q - CNT_W'(1));
			end
			S_SH_WR: begin
				we    = 1'b1;
				waddr = k_q[IDX_W-1:0];
				wdata = rd_e;
			end
			S_SP_HI: begin
				we    = 1'b1;
				waddr = i_q + IDX_W'(1);
				wdata = '{busy: 1'b0, owner: 8'd0, length: ent_q.length - req_q,
					start: ent_q.start + req_q};
			end
			S_SP_LO: begin
				we    = 1'b1;
				wdata = '{busy: 1'b1, owner: id_q, length: req_q, start: ent_q.start};
			end
			S_F_CHK: begin
				if (acc_v_q && !merge) begin
					we    = 1'b1;
					waddr = w_q;
					wdata = acc_q;
				end
			end
			S_F_FL: begin
				we    = 1'b1;
				waddr = w_q;
				wdata = acc_q;
			end
			S_IDLE, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q   <= CNT_W'(1);
			i_q     <= '0;
			w_q     <= '0;
			k_q     <= '0;
			acc_v_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					cnt_q   <= CNT_W'(1);
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (init) begin
						state_q <= S_INIT;
					end else if (start) begin
						id_q    <= owner_id;
						req_q   <= ADDR_BITS'(req_size);
						i_q     <= '0;
						w_q     <= '0;
						acc_v_q <= 1'b0;
						found_q <= 1'b0;
						addr_q  <= '0;
						if (op == OP_FREE) begin
							state_q <= S_F_RD;
						end else if (req_size == 16'd0) begin
							status_q <= ST_ZERO;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_A_RD;
						end
					end
				end
				S_A_RD: begin
					state_q <= S_A_CHK;
				end
				S_A_CHK: begin
					if (fit) begin
						if (exact) begin
							status_q <= ST_OK;
							addr_q   <= 16'(rd_e.start);
							state_q  <= S_DONE;
						end else if (cnt_q >= CNT_W'(MAX_SEGMENTS)) begin
							status_q <= ST_FULL;
							state_q  <= S_DONE;
						end else begin
							ent_q <= rd_e;
							k_q   <= cnt_q;
							if (cnt_q == ({1'b0, i_q} + CNT_W'(1))) begin
								state_q <= S_SP_HI;
							end else begin
								state_q <= S_SH_RD;
							end
						end
					end else if (last) begin
						status_q <= ST_NOFIT;
						state_q  <= S_DONE;
					end else begin
						i_q     <= i_q + IDX_W'(1);
						state_q <= S_A_RD;
					end
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					// advance downward; stop once the slot above the split is open
					k_q <= k_q - CNT_W'(1);
					if ((k_q - CNT_W'(1)) == ({1'b0, i_q} + CNT_W'(1))) begin
						state_q <= S_SP_HI;
					end else begin
						state_q <= S_SH_RD;
					end
				end
				S_SP_HI: begin
					state_q <= S_SP_LO;
				end
				S_SP_LO: begin
					cnt_q    <= cnt_q + CNT_W'(1);
					status_q <= ST_OK;
					addr_q   <= 16'(ent_q.start);
					state_q  <= S_DONE;
				end
				S_F_RD: begin
					state_q <= S_F_CHK;
				end
				S_F_CHK: begin
					if (hit) begin
						found_q <= 1'b1;
					end
					if (merge) begin
						acc_q.length <= acc_q.length + d_free.length;
					end else begin
						if (acc_v_q) begin
							w_q <= w_q + IDX_W'(1);
						end
						acc_q   <= d_free;
						acc_v_q <= 1'b1;
					end
					if (last) begin
						state_q <= S_F_FL;
					end else begin
						i_q     <= i_q + IDX_W'(1);
						state_q <= S_F_RD;
					end
				end
				S_F_FL: begin
					cnt_q    <= {1'b0, w_q} + CNT_W'(1);
					status_q <= found_q ? ST_OK : ST_NOID;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle       = (state_q == S_IDLE);
	assign res.valid  = (state_q == S_DONE);
	assign res.status = status_q;
	assign res.addr   = addr_q;
endmodule

// ===== hdl/first_fit_segment_allocator_core.sv =====
// Top level of the first-fit segment allocator: channels, size register, result register.
// Operation: an allocate reads and checks table entries in order up to the first fit;
//   on a split it moves the later entries up, writes both halves and posts the result;
//   a zero-size allocate skips the scan. A free reads and compacts every entry.
// Throughput: one transaction at a time; after the result moves to the output register
//   the sequencer returns to idle and accepts the next request unless a configuration
//   write is offered. Reset: total_size returns to 1024 and one free segment is rebuilt.
module first_fit_segment_allocator_core (
	input logic         clk,
	input logic         arst_n,
	ffsa_cfg_if.sink    cfg,
	ffsa_req_if.sink    req,
	ffsa_rsp_if.source  rsp
);
	import ffsa_pkg::*;

	logic [15:0] total_size_q;
	logic        out_valid_q;
	status_t     out_status_q;
	logic [15:0] out_addr_q;

	logic        seq_idle;
	result_t     seq_res;
	logic        res_take;
	logic        cfg_fire;
	logic        req_fire;

	// Configuration and new requests both wait for an idle sequencer.
	assign cfg.ready = seq_idle;
	assign cfg_fire  = cfg.valid && cfg.ready;

	// Hold requests off while a configuration write is offered so the table
	// rebuild always wins.
	assign req.ready = seq_idle && !cfg.valid;
	assign req_fire  = req.valid && req.ready;

	// Move a finished result into the output register when it is empty or draining.
	assign res_take = seq_res.valid && (!out_valid_q || rsp.ready);

	ffsa_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.init      (cfg_fire),
		.total_size(total_size_q),
		.start     (req_fire),
		.op        (req.op),
		.owner_id  (req.owner_id),
		.req_size  (req.req_size),
		.idle      (seq_idle),
		.res       (seq_res),
		.res_take  (res_take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_size_q <= TOTAL_SIZE_RESET;
		end else if (cfg_fire) begin
			total_size_q <= cfg.total_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_status_q <= seq_res.status;
			out_addr_q   <= seq_res.addr;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.start_addr = out_addr_q;
endmodule
